FILE: hdl/tsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tile map scroll window core.
// Depends on nothing; every other file in hdl/ uses it by scoped names.
package tsw_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_SHIFT_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_SHIFT_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_TILES_X   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_TILES_Y   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_HEIGHT = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [2:0]  RESET_TILE_SHIFT = 3'd3;
   localparam logic [9:0]  RESET_MAP_TILES  = 10'd64;
   localparam logic [10:0] RESET_WINDOW_W   = 11'd319;
   localparam logic [10:0] RESET_WINDOW_H   = 11'd239;

   // Bit positions of the direction codes in way and blocked.
   localparam int unsigned WAY_UP_BIT    = 0;
   localparam int unsigned WAY_DOWN_BIT  = 1;
   localparam int unsigned WAY_LEFT_BIT  = 2;
   localparam int unsigned WAY_RIGHT_BIT = 3;

   // Item kinds.
   localparam logic KIND_RELATIVE = 1'b0;
   localparam logic KIND_ABSOLUTE = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [3:0]  way;
      logic [15:0] amount;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [3:0]  blocked;
      logic [15:0] scroll_x;
      logic [15:0] scroll_y;
      logic [15:0] first_tile_x;
      logic [15:0] first_tile_y;
      logic [6:0]  fine_x;
      logic [6:0]  fine_y;
      logic [11:0] tiles_across;
      logic [11:0] tiles_down;
   } rsp_type;

   // Geometry of one axis, as held in the configuration registers.
   typedef struct packed {
      logic [2:0]  shift;
      logic [9:0]  map_tiles;
      logic [10:0] window;
   } axis_cfg_type;

   // What one axis unit hands back for an item.
   typedef struct packed {
      logic [15:0] pos;
      logic [15:0] first_tile;
      logic [6:0]  fine;
      logic [11:0] tiles;
      logic        dec_hit;
      logic        inc_hit;
   } axis_res_type;

endpackage

FILE: hdl/tsw_csr.sv
`timescale 1ns / 1ps
// Configuration register file of the tile map scroll window core.
// Depends on tsw_pkg for register indexes, reset values and axis_cfg_type.
module tsw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsw_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output tsw_pkg::axis_cfg_type               cfg_x,
   output tsw_pkg::axis_cfg_type               cfg_y
);

   tsw_pkg::axis_cfg_type cfg_x_ff, cfg_x_in;
   tsw_pkg::axis_cfg_type cfg_y_ff, cfg_y_in;

   // Writes are always taken: csr_ready is tied high.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_x_in = cfg_x_ff;
      cfg_y_in = cfg_y_ff;
      if (csr_valid) begin
         case (csr_index)
            tsw_pkg::CSR_TILE_SHIFT_X:  cfg_x_in.shift     = csr_wdata[2:0];
            tsw_pkg::CSR_TILE_SHIFT_Y:  cfg_y_in.shift     = csr_wdata[2:0];
            tsw_pkg::CSR_MAP_TILES_X:   cfg_x_in.map_tiles = csr_wdata[9:0];
            tsw_pkg::CSR_MAP_TILES_Y:   cfg_y_in.map_tiles = csr_wdata[9:0];
            tsw_pkg::CSR_WINDOW_WIDTH:  cfg_x_in.window    = csr_wdata;
            tsw_pkg::CSR_WINDOW_HEIGHT: cfg_y_in.window    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_x_ff <= '{shift: tsw_pkg::RESET_TILE_SHIFT, map_tiles: tsw_pkg::RESET_MAP_TILES,
                       window: tsw_pkg::RESET_WINDOW_W};
         cfg_y_ff <= '{shift: tsw_pkg::RESET_TILE_SHIFT, map_tiles: tsw_pkg::RESET_MAP_TILES,
                       window: tsw_pkg::RESET_WINDOW_H};
      end else begin
         cfg_x_ff <= cfg_x_in;
         cfg_y_ff <= cfg_y_in;
      end
   end

   assign cfg_x = cfg_x_ff;
   assign cfg_y = cfg_y_ff;

endmodule

FILE: hdl/tsw_axis.sv
`timescale 1ns / 1ps
// One axis of the scroll window: clamped move toward zero, then away from zero,
// or an absolute load; then tile, fine offset and tile count. Depends on tsw_pkg.
module tsw_axis (
   input  tsw_pkg::axis_cfg_type cfg,
   input  logic [15:0]           pos,
   input  logic                  set_en,
   input  logic [15:0]           set_pos,
   input  logic                  dec_en,
   input  logic                  inc_en,
   input  logic [15:0]           amount,
   output tsw_pkg::axis_res_type res
);

   logic [16:0] map_px;
   logic [16:0] diff;
   logic [15:0] limit;
   logic [15:0] pos_dec;
   logic        dec_hit;
   logic [16:0] sum;
   logic [15:0] pos_inc;
   logic        inc_hit;
   logic [15:0] pos_new;
   logic [6:0]  fine_mask;
   logic [6:0]  fine;
   logic [7:0]  tile_size;
   logic [10:0] uncut;
   logic [7:0]  rest;
   logic [7:0]  rest_left;
   logic        more;

   // Largest scroll: map pixels minus window, floored at zero and capped at 16 bits.
   always_comb begin
      map_px = 17'(cfg.map_tiles) << cfg.shift;
      if (map_px > 17'(cfg.window)) begin
         diff = map_px - 17'(cfg.window);
      end else begin
         diff = '0;
      end
      limit = diff[16] ? 16'hFFFF : diff[15:0];
   end

   // Move toward zero first, then away from zero from where that left us.
   always_comb begin
      pos_dec = pos;
      dec_hit = 1'b0;
      if (dec_en) begin
         if (amount > pos) begin
            pos_dec = '0;
            dec_hit = 1'b1;
         end else begin
            pos_dec = pos - amount;
         end
      end

      sum     = 17'(pos_dec) + 17'(amount);
      pos_inc = pos_dec;
      inc_hit = 1'b0;
      if (inc_en && (amount != '0)) begin
         if (pos_dec >= limit) begin
            inc_hit = 1'b1;
         end else if (sum > 17'(limit)) begin
            pos_inc = limit;
            inc_hit = 1'b1;
         end else begin
            pos_inc = sum[15:0];
         end
      end

      pos_new = set_en ? set_pos : pos_inc;
   end

   // Tile position and the count of tiles the window touches.
   always_comb begin
      fine_mask = 7'((8'd1 << cfg.shift) - 8'd1);
      fine      = pos_new[6:0] & fine_mask;
      tile_size = 8'd1 << cfg.shift;
      uncut     = cfg.window >> cfg.shift;
      rest      = 8'(cfg.window[6:0] & fine_mask) + 8'(fine);
      more      = (rest >= tile_size);
      rest_left = more ? (rest - tile_size) : rest;
   end

   always_comb begin
      res.pos        = pos_new;
      res.first_tile = pos_new >> cfg.shift;
      res.fine       = fine;
      res.tiles      = 12'(uncut) + 12'(more) + 12'(rest_left != '0);
      res.dec_hit    = dec_hit && !set_en;
      res.inc_hit    = inc_hit && !set_en;
   end

endmodule

FILE: hdl/tilemap_scroll_window_core.sv
`timescale 1ns / 1ps
// Top level of the tile map scroll window core: handshakes, position state,
// input and result registers. Depends on tsw_pkg, tsw_csr and tsw_axis.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------
//   req_    | in        | req_valid/req_stall | req_data  (tsw_pkg::req_type)
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_data  (tsw_pkg::rsp_type)
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One item is accepted every cycle while req_stall is low. An item is held in the
// input register, is worked out against the held scroll position, and lands in
// the result register, from which it can transfer out when rsp_stall is low.
// The rate is set by the single pass through the two axis units, which also
// write the new position back in that same cycle.
// Reset is synchronous and active high; it clears both valid flags, the scroll
// position (to zero) and the configuration registers (to their defaults).
// A stalled result holds in the result register while the input register still
// takes one more item; only when both are full does req_stall rise.
module tilemap_scroll_window_core (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  tsw_pkg::req_type                    req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tsw_pkg::rsp_type                    rsp_data,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tsw_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   tsw_pkg::axis_cfg_type cfg_x;
   tsw_pkg::axis_cfg_type cfg_y;

   // Input register.
   logic             in_valid_ff, in_valid_in;
   tsw_pkg::req_type in_data_ff,  in_data_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   tsw_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Scroll position.
   logic [15:0] pos_x_ff, pos_x_in;
   logic [15:0] pos_y_ff, pos_y_in;

   logic out_free;
   logic advance;
   logic req_take;
   logic set_en;

   tsw_pkg::axis_res_type res_x;
   tsw_pkg::axis_res_type res_y;

   tsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_x     (cfg_x),
      .cfg_y     (cfg_y)
   );

   // The result register can take a new item when it is empty or being drained.
   // The input register moves on whenever the result register can take its item.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign set_en = (in_data_ff.kind == tsw_pkg::KIND_ABSOLUTE);

   // Vertical axis handles up then down; horizontal handles left then right.
   tsw_axis u_axis_y (
      .cfg     (cfg_y),
      .pos     (pos_y_ff),
      .set_en  (set_en),
      .set_pos (in_data_ff.pos_y),
      .dec_en  (in_data_ff.way[tsw_pkg::WAY_UP_BIT]),
      .inc_en  (in_data_ff.way[tsw_pkg::WAY_DOWN_BIT]),
      .amount  (in_data_ff.amount),
      .res     (res_y)
   );

   tsw_axis u_axis_x (
      .cfg     (cfg_x),
      .pos     (pos_x_ff),
      .set_en  (set_en),
      .set_pos (in_data_ff.pos_x),
      .dec_en  (in_data_ff.way[tsw_pkg::WAY_LEFT_BIT]),
      .inc_en  (in_data_ff.way[tsw_pkg::WAY_RIGHT_BIT]),
      .amount  (in_data_ff.amount),
      .res     (res_x)
   );

   always_comb begin
      // When the input side is not stalled the input register either is empty
      // or hands its item on this cycle, so it simply follows req_valid.
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_data_in  = req_take ? req_data : in_data_ff;

      rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

      rsp_data_in = rsp_data_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      if (advance) begin
         rsp_data_in.blocked[tsw_pkg::WAY_UP_BIT]    = res_y.dec_hit;
         rsp_data_in.blocked[tsw_pkg::WAY_DOWN_BIT]  = res_y.inc_hit;
         rsp_data_in.blocked[tsw_pkg::WAY_LEFT_BIT]  = res_x.dec_hit;
         rsp_data_in.blocked[tsw_pkg::WAY_RIGHT_BIT] = res_x.inc_hit;
         rsp_data_in.scroll_x     = res_x.pos;
         rsp_data_in.scroll_y     = res_y.pos;
         rsp_data_in.first_tile_x = res_x.first_tile;
         rsp_data_in.first_tile_y = res_y.first_tile;
         rsp_data_in.fine_x       = res_x.fine;
         rsp_data_in.fine_y       = res_y.fine;
         rsp_data_in.tiles_across = res_x.tiles;
         rsp_data_in.tiles_down   = res_y.tiles;
         pos_x_in = res_x.pos;
         pos_y_in = res_y.pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/tilemap_scroll_window_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tilemap_scroll_window_core: directed and random scroll items
// under random valid and stall pacing, checked against a cycle-free model of the scroll state.
// Depends on tsw_pkg and the core RTL only.
module tilemap_scroll_window_core_tb;
   import tsw_pkg::*;

   // Direction codes in way and blocked, built from the package bit positions.
   localparam logic [3:0] GO_UP    = 4'(1 << WAY_UP_BIT);
   localparam logic [3:0] GO_DOWN  = 4'(1 << WAY_DOWN_BIT);
   localparam logic [3:0] GO_LEFT  = 4'(1 << WAY_LEFT_BIT);
   localparam logic [3:0] GO_RIGHT = 4'(1 << WAY_RIGHT_BIT);
   localparam logic [3:0] GO_ALL   = GO_UP | GO_DOWN | GO_LEFT | GO_RIGHT;

   // Far above the expected run: about 1520 items with random sender gaps and receiver
   // stalls, plus the drains between phases.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // Scroll position model. It holds its own copy of the geometry registers and the
   // position, predicts one result per accepted item and checks results in order.
   class scroll_board;
      logic [2:0]  shift_x, shift_y;
      logic [9:0]  map_w, map_h;
      logic [10:0] view_w, view_h;
      int unsigned cur_x, cur_y;
      rsp_type     due[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         shift_x    = RESET_TILE_SHIFT;
         shift_y    = RESET_TILE_SHIFT;
         map_w      = RESET_MAP_TILES;
         map_h      = RESET_MAP_TILES;
         view_w     = RESET_WINDOW_W;
         view_h     = RESET_WINDOW_H;
         cur_x      = 0;
         cur_y      = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [10:0] value);
         case (index)
            CSR_TILE_SHIFT_X:  shift_x = value[2:0];
            CSR_TILE_SHIFT_Y:  shift_y = value[2:0];
            CSR_MAP_TILES_X:   map_w   = value[9:0];
            CSR_MAP_TILES_Y:   map_h   = value[9:0];
            CSR_WINDOW_WIDTH:  view_w  = value;
            CSR_WINDOW_HEIGHT: view_h  = value;
            default: ;
         endcase
      endfunction

      // Map pixels minus window pixels, floored at zero and saturated to 16 bits.
      function int unsigned largest(logic [9:0] tiles, logic [2:0] shift, logic [10:0] view);
         int unsigned px;
         px = tiles;
         px = px << shift;
         if (px <= view) return 0;
         px = px - view;
         return (px > 65535) ? 65535 : px;
      endfunction

      function int unsigned limit_x();
         return largest(map_w, shift_x, view_w);
      endfunction

      function int unsigned limit_y();
         return largest(map_h, shift_y, view_h);
      endfunction

      // Move toward zero; a move that overshoots stops at zero and is flagged.
      function bit back_off(inout int unsigned pos, input int unsigned amt);
         if (amt > pos) begin
            pos = 0;
            return 1'b1;
         end
         pos = pos - amt;
         return 1'b0;
      endfunction

      // Move toward the limit. A position already at or past the limit does not move,
      // but any non-zero move against it is flagged.
      function bit push_on(inout int unsigned pos, input int unsigned amt,
                           input int unsigned lim);
         if (amt == 0) return 1'b0;
         if (pos >= lim) return 1'b1;
         if (pos + amt > lim) begin
            pos = lim;
            return 1'b1;
         end
         pos = pos + amt;
         return 1'b0;
      endfunction

      // Whole tiles in the window, plus one for the carry of leftover pixels and fine
      // offset, plus one more if anything is still left over.
      function int unsigned tiles_to_draw(logic [10:0] view, logic [2:0] shift,
                                          int unsigned fine);
         int unsigned size, uncut, rest, more;
         size  = 1 << shift;
         uncut = view >> shift;
         rest  = (view & (size - 1)) + fine;
         more  = 0;
         if (rest >= size) begin
            more = 1;
            rest = rest - size;
         end
         return uncut + more + ((rest != 0) ? 1 : 0);
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned lim_x, lim_y, fx, fy;
         e = '0;
         if (r.kind == KIND_ABSOLUTE) begin
            cur_x = r.pos_x;
            cur_y = r.pos_y;
         end else begin
            lim_x = limit_x();
            lim_y = limit_y();
            // Order matters: up, down, left, right.
            if ((r.way & GO_UP) != 0 && back_off(cur_y, r.amount)) e.blocked |= GO_UP;
            if ((r.way & GO_DOWN) != 0 && push_on(cur_y, r.amount, lim_y))
               e.blocked |= GO_DOWN;
            if ((r.way & GO_LEFT) != 0 && back_off(cur_x, r.amount)) e.blocked |= GO_LEFT;
            if ((r.way & GO_RIGHT) != 0 && push_on(cur_x, r.amount, lim_x))
               e.blocked |= GO_RIGHT;
         end
         fx = cur_x & ((1 << shift_x) - 1);
         fy = cur_y & ((1 << shift_y) - 1);
         e.scroll_x     = 16'(cur_x);
         e.scroll_y     = 16'(cur_y);
         e.first_tile_x = 16'(cur_x >> shift_x);
         e.first_tile_y = 16'(cur_y >> shift_y);
         e.fine_x       = 7'(fx);
         e.fine_y       = 7'(fy);
         e.tiles_across = 12'(tiles_to_draw(view_w, shift_x, fx));
         e.tiles_down   = 12'(tiles_to_draw(view_h, shift_y, fy));
         due.push_back(e);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d field %s: expected %0d, got %0d", checked, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d arrived with nothing expected: %h", checked, got);
            return;
         end
         e = due.pop_front();
         compare_field("blocked", 16'(e.blocked), 16'(got.blocked));
         compare_field("scroll_x", e.scroll_x, got.scroll_x);
         compare_field("scroll_y", e.scroll_y, got.scroll_y);
         compare_field("first_tile_x", e.first_tile_x, got.first_tile_x);
         compare_field("first_tile_y", e.first_tile_y, got.first_tile_y);
         compare_field("fine_x", 16'(e.fine_x), 16'(got.fine_x));
         compare_field("fine_y", 16'(e.fine_y), 16'(got.fine_y));
         compare_field("tiles_across", 16'(e.tiles_across), 16'(got.tiles_across));
         compare_field("tiles_down", 16'(e.tiles_down), 16'(got.tiles_down));
         checked++;
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   scroll_board board;
   // Percent of cycles in which the sender holds back and the receiver stalls.
   int unsigned send_pct = 29;
   int unsigned hold_pct = 49;
   int unsigned cycle_count = 0;

   tilemap_scroll_window_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog. A hang anywhere in the handshakes ends the run here.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Result side. The values seen at the edge are the ones before it, so a transfer
   // is a cycle where rsp_valid was high and our own stall was low. The stall for the
   // next cycle is then chosen at random by the current pacing.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) board.check_result(rsp_data);
         rsp_stall <= !reset && ($urandom_range(99) < hold_pct);
      end
   end

   // Offers one item and holds it until a transfer takes place. Valid is lowered only
   // while the sender idles, so a back-to-back item never sees valid dropped and
   // raised within one step.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
   endtask

   // The sender stops and waits until every expected result has been taken, so that
   // the block is fully idle before any register write.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; valid stays high so that writes can follow back to back.
   task automatic put_register(input logic [2:0] index, input logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_register(index, value);
   endtask

   // Writes all six geometry registers. Unused high bits of the narrow registers carry
   // random junk, which the block must drop. With junk set, a write to an index past
   // the last register is slipped in as well and must change nothing.
   task automatic apply_geometry(input logic [2:0] sx, input logic [2:0] sy,
                                 input logic [9:0] mx, input logic [9:0] my,
                                 input logic [10:0] ww, input logic [10:0] wh,
                                 input bit junk);
      put_register(CSR_TILE_SHIFT_X, (11'($urandom) & 11'h7F8) | 11'(sx));
      put_register(CSR_TILE_SHIFT_Y, (11'($urandom) & 11'h7F8) | 11'(sy));
      if (junk) put_register(3'(CSR_WINDOW_HEIGHT + $urandom_range(1, 2)), 11'($urandom));
      put_register(CSR_MAP_TILES_X, (11'($urandom) & 11'h400) | 11'(mx));
      put_register(CSR_MAP_TILES_Y, (11'($urandom) & 11'h400) | 11'(my));
      put_register(CSR_WINDOW_WIDTH, ww);
      put_register(CSR_WINDOW_HEIGHT, wh);
      csr_valid <= 1'b0;
   endtask

   // Builds one item from the given fields. Callers often pass random values for fields that an item does not use.
   function automatic req_type make_req(input logic kind, input logic [3:0] way,
                                        input logic [15:0] amount,
                                        input logic [15:0] px, input logic [15:0] py);
      req_type r;
      r.kind   = kind;
      r.way    = way;
      r.amount = amount;
      r.pos_x  = px;
      r.pos_y  = py;
      return r;
   endfunction

   // Random geometry: maps mostly, and windows half of the time, of a size where the largest
   // scroll lands in an interesting range; otherwise anywhere in the register range.
   task automatic random_geometry();
      logic [2:0]  sx, sy;
      logic [9:0]  mx, my;
      logic [10:0] ww, wh;
      sx = 3'($urandom_range(7));
      sy = 3'($urandom_range(7));
      mx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 80));
      my = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 80));
      ww = ($urandom_range(1) == 0) ? 11'($urandom_range(0, 300)) : 11'($urandom);
      wh = ($urandom_range(1) == 0) ? 11'($urandom_range(0, 300)) : 11'($urandom);
      apply_geometry(sx, sy, mx, my, ww, wh, $urandom_range(3) == 0);
   endtask

   function automatic logic [15:0] random_spot(input int unsigned lim);
      case ($urandom_range(4))
         0: return 16'($urandom);
         1: return 16'(lim);
         2: return 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, lim));
      endcase
   endfunction

   // Mostly relative moves with small to mid amounts so that the position wanders
   // between the two limits; now and then huge or zero amounts, and absolute loads
   // both inside and beyond the scrollable range.
   function automatic req_type random_req();
      req_type     r;
      int unsigned pick;
      r = make_req(KIND_RELATIVE, 4'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.kind  = KIND_ABSOLUTE;
         r.pos_x = random_spot(board.limit_x());
         r.pos_y = random_spot(board.limit_y());
      end else if (pick < 50) begin
         r.amount = 16'($urandom_range(1, 64));
      end else if (pick < 75) begin
         r.amount = 16'($urandom_range(0, 1023));
      end else if (pick < 85) begin
         r.amount = 16'd0;
      end else if (pick < 90) begin
         r.amount = 16'hFFFF;
      end
      return r;
   endfunction

   initial begin
      board = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset geometry: largest scroll is 193 across and 273 down.
      send_item(make_req(KIND_RELATIVE, GO_UP, 16'd5, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_LEFT, 16'd0, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_DOWN, 16'd100, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_DOWN, 16'hFFFF, 16'($urandom), 16'($urandom)));
      // Already sitting on the limit: no movement but still flagged.
      send_item(make_req(KIND_RELATIVE, GO_DOWN, 16'd1, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_RIGHT, 16'hFFFF, 16'($urandom), 16'($urandom)));
      // All four directions at once; the order up, down, left, right decides the outcome.
      send_item(make_req(KIND_RELATIVE, GO_ALL, 16'd50, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_ALL, 16'd0, 16'($urandom), 16'($urandom)));
      send_item(make_req(KIND_RELATIVE, GO_LEFT, 16'hFFFF, 16'($urandom), 16'($urandom)));
      // Absolute load far past the limit, then moves against and away from it.
      send_item(make_req(KIND_ABSOLUTE, GO_ALL, 16'($urandom), 16'hFFFF, 16'hFFFF));
      send_item(make_req(KIND_RELATIVE, GO_DOWN | GO_RIGHT, 16'd1, 16'd0, 16'd0));
      send_item(make_req(KIND_RELATIVE, GO_UP | GO_LEFT, 16'd1, 16'd0, 16'd0));
      send_item(make_req(KIND_ABSOLUTE, 4'd0, 16'hFFFF, 16'd0, 16'd0));
      send_item(make_req(KIND_RELATIVE, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_item(make_req(KIND_ABSOLUTE, 4'($urandom), 16'($urandom), 16'hAAAA, 16'h5555));
      wait_for_results();

      // Smallest geometry: one-pixel tiles, an empty map and an empty window.
      apply_geometry(3'd0, 3'd0, 10'd0, 10'd0, 11'd0, 11'd0, 1'b1);
      send_item(make_req(KIND_RELATIVE, GO_RIGHT | GO_UP, 16'd1, 16'd0, 16'd0));
      send_item(make_req(KIND_ABSOLUTE, 4'd0, 16'd0, 16'd12345, 16'd54321));
      send_item(make_req(KIND_RELATIVE, GO_ALL, 16'd1, 16'd0, 16'd0));
      wait_for_results();

      // Largest geometry: the map overflows 16 bits, so the limit saturates.
      apply_geometry(3'd7, 3'd7, 10'h3FF, 10'h3FF, 11'h7FF, 11'h7FF, 1'b0);
      send_item(make_req(KIND_ABSOLUTE, 4'd0, 16'd0, 16'd127, 16'd129));
      send_item(make_req(KIND_RELATIVE, GO_DOWN | GO_RIGHT, 16'hFFFF, 16'd0, 16'd0));
      send_item(make_req(KIND_RELATIVE, GO_DOWN | GO_LEFT, 16'd1, 16'd0, 16'd0));
      wait_for_results();

      // Window at least as large as the map: nothing can scroll.
      apply_geometry(3'd1, 3'd2, 10'd10, 10'd5, 11'd100, 11'd20, 1'b0);
      send_item(make_req(KIND_RELATIVE, GO_DOWN | GO_RIGHT, 16'd3, 16'd0, 16'd0));
      send_item(make_req(KIND_ABSOLUTE, 4'd0, 16'd0, 16'd7, 16'd3));
      wait_for_results();

      // Random phases. Each gets fresh geometry on an idle block; the pacing moves from
      // a slow receiver, to a slow sender, to full rate with no gaps at all.
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin
            send_pct = 49;
            hold_pct = 29;
         end
         if (phase == 8) begin
            send_pct = 0;
            hold_pct = 0;
         end
         random_geometry();
         repeat (125) send_item(random_req());
         wait_for_results();
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/tsw_pkg.sv
hdl/tsw_csr.sv
hdl/tsw_axis.sv
hdl/tilemap_scroll_window_core.sv
test/tilemap_scroll_window_core_tb.sv
